@@ rtl/core/fhc_pkg.sv @@
// Shared types, constants and the fixed code table of the text codec.
package fhc_pkg;

  localparam int WORD_BITS  = 64;
  localparam int NUM_SYMS   = 29;
  localparam int LEN_W      = 4;
  localparam int CODE_W     = 8;
  localparam int CHAR_W     = 8;
  localparam int FILL_W     = $clog2(WORD_BITS + 1);
  localparam int OUT_WORD_W = 64;
  localparam int USED_W     = 7;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_PERIOD = 8'h2E;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } fhc_op_t;

  typedef enum logic [1:0] {
    KIND_PACKED  = 2'd0,
    KIND_CHAR    = 2'd1,
    KIND_NOMATCH = 2'd2
  } fhc_kind_t;

  // Table order sets match priority on decode.
  localparam logic [CHAR_W-1:0] SYM_CH [NUM_SYMS] = '{
    8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68,
    8'h69, 8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70,
    8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78,
    8'h79, 8'h7A, 8'h2C, 8'h2E, 8'h20
  };
  localparam logic [LEN_W-1:0] SYM_LEN [NUM_SYMS] = '{
    4'd4, 4'd7, 4'd4, 4'd4, 4'd4, 4'd5, 4'd6, 4'd5,
    4'd4, 4'd8, 4'd8, 4'd5, 4'd5, 4'd4, 4'd4, 4'd5,
    4'd8, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd8,
    4'd6, 4'd8, 4'd7, 4'd6, 4'd3
  };
  localparam logic [CODE_W-1:0] SYM_CODE [NUM_SYMS] = '{
    8'h09, 8'h42, 8'h01, 8'h04, 8'h0E, 8'h1B, 8'h00, 8'h1A,
    8'h06, 8'h07, 8'h54, 8'h01, 8'h1E, 8'h07, 8'h0C, 8'h0B,
    8'h55, 8'h1F, 8'h03, 8'h02, 8'h11, 8'h87, 8'h02, 8'h06,
    8'h20, 8'h86, 8'h2B, 8'h14, 8'h05
  };

  typedef struct packed {
    fhc_op_t                op;
    logic                   eot;
    logic                   hit;
    logic [LEN_W-1:0]       len;
    logic [CODE_W-1:0]      code;
    logic [WORD_BITS-1:0]   word;
  } fhc_cmd_t;

  typedef struct packed {
    logic [OUT_WORD_W-1:0]  packed_out;
    fhc_kind_t              kind;
    logic [CHAR_W-1:0]      char_out;
    logic                   overflowed;
    logic [USED_W-1:0]      bits_used;
    logic                   last_result;
  } fhc_res_t;

  typedef struct packed {
    logic                   full;
    logic                   empty;
    logic [Q_CNT_W-1:0]     count;
  } fhc_q_stat_t;

  typedef struct packed {
    logic                   busy;
    logic                   pop;
  } fhc_bk_stat_t;

  typedef struct packed {
    logic                   hit;
    logic [LEN_W-1:0]       len;
    logic [CODE_W-1:0]      code;
  } fhc_sym_t;

  function automatic fhc_sym_t fhc_lookup(input logic [CHAR_W-1:0] sym);
    fhc_sym_t r;
    r = '0;
    for (int k = 0; k < NUM_SYMS; k++) begin
      if (!r.hit && SYM_CH[k] == sym) begin
        r.hit  = 1'b1;
        r.len  = SYM_LEN[k];
        r.code = SYM_CODE[k];
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/core/fhc_in_if.sv @@
// Request channel carrying characters to encode and words to decode.
interface fhc_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  symbol;
  logic        end_of_text;
  logic [63:0] packed_in;

  modport source (output valid, op, symbol, end_of_text, packed_in, input ready);
  modport sink   (input valid, op, symbol, end_of_text, packed_in, output ready);
endinterface

@@ rtl/core/fhc_out_if.sv @@
// Result channel carrying packed words and decoded characters.
interface fhc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] packed_out;
  logic [1:0]  kind;
  logic [7:0]  char_out;
  logic        overflowed;
  logic [6:0]  bits_used;
  logic        last_result;

  modport source (output valid, packed_out, kind, char_out, overflowed, bits_used,
                  last_result, input ready);
  modport sink   (input valid, packed_out, kind, char_out, overflowed, bits_used,
                  last_result, output ready);
endinterface

@@ rtl/core/fhc_front.sv @@
// Front end: accept requests and classify the character against the code table.
module fhc_front (
  fhc_in_if.sink             in_ch,
  input  fhc_pkg::fhc_q_stat_t q_stat,
  output logic               push,
  output fhc_pkg::fhc_cmd_t  push_cmd
);
  import fhc_pkg::*;

  fhc_sym_t sym;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  always_comb begin
    sym           = fhc_lookup(in_ch.symbol);
    push_cmd.op   = fhc_op_t'(in_ch.op);
    push_cmd.eot  = in_ch.end_of_text;
    push_cmd.hit  = sym.hit;
    push_cmd.len  = sym.len;
    push_cmd.code = sym.code;
    push_cmd.word = in_ch.packed_in[WORD_BITS-1:0];
  end

endmodule

@@ rtl/core/fhc_queue.sv @@
// Short queue of classified requests between front and back end.
module fhc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  fhc_pkg::fhc_cmd_t    push_cmd,
  input  logic                 pop,
  output fhc_pkg::fhc_cmd_t    head,
  output fhc_pkg::fhc_q_stat_t q_stat
);
  import fhc_pkg::*;

  fhc_cmd_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 do_push, do_pop;

  assign q_stat.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign q_stat.count = count_r;
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    do_push    = push && !q_stat.full;
    do_pop     = pop && !q_stat.empty;
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/core/fhc_back.sv @@
// Back end: encoder, one-symbol-per-cycle decoder when unstalled, result register.
module fhc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fhc_pkg::fhc_cmd_t     head,
  input  fhc_pkg::fhc_q_stat_t  q_stat,
  output fhc_pkg::fhc_bk_stat_t bk_stat,
  fhc_out_if.source             out_ch
);
  import fhc_pkg::*;

  logic                 out_valid_r, out_valid_nxt;
  fhc_res_t             out_res_r, out_res_nxt;
  logic                 busy_r, busy_nxt;
  logic [WORD_BITS-1:0] dec_word_r, dec_word_nxt;
  logic [FILL_W-1:0]    remaining_r, remaining_nxt;
  logic [WORD_BITS-1:0] enc_word_r, enc_word_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic                 ovf_r, ovf_nxt;

  logic                 can_load, pop, out_load;
  fhc_res_t             res;
  logic [CODE_W-1:0]    window;
  logic                 found;
  logic [LEN_W-1:0]     m_len;
  logic [CHAR_W-1:0]    m_ch;
  logic [FILL_W-1:0]    rem_after;
  logic                 fits, enc_upd;
  logic [FILL_W-1:0]    fill_sub;
  logic [WORD_BITS-1:0] ins;
  logic [WORD_BITS-1:0] ew;
  logic [FILL_W-1:0]    ef;
  logic                 eo;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.packed_out  = out_res_r.packed_out;
  assign out_ch.kind        = out_res_r.kind;
  assign out_ch.char_out    = out_res_r.char_out;
  assign out_ch.overflowed  = out_res_r.overflowed;
  assign out_ch.bits_used   = out_res_r.bits_used;
  assign out_ch.last_result = out_res_r.last_result;

  assign bk_stat.busy = busy_r;
  assign bk_stat.pop  = pop;

  // Decode match: first table entry whose code fits and equals the top bits.
  always_comb begin
    window = dec_word_r[WORD_BITS-1 -: CODE_W];
    found  = 1'b0;
    m_len  = '0;
    m_ch   = '0;
    for (int k = 0; k < NUM_SYMS; k++) begin
      if (!found && FILL_W'(SYM_LEN[k]) <= remaining_r &&
          (window >> (LEN_W'(CODE_W) - SYM_LEN[k])) == SYM_CODE[k]) begin
        found = 1'b1;
        m_len = SYM_LEN[k];
        m_ch  = SYM_CH[k];
      end
    end
    rem_after = remaining_r - FILL_W'(m_len);
  end

  // Encode update for the request at the queue head.
  always_comb begin
    enc_upd  = head.hit && !ovf_r;
    fits     = FILL_W'(head.len) <= fill_r;
    fill_sub = fill_r - FILL_W'(head.len);
    ins      = WORD_BITS'(head.code) << fill_sub;
    ew       = (enc_upd && fits) ? (enc_word_r | ins) : enc_word_r;
    ef       = (enc_upd && fits) ? fill_sub : fill_r;
    eo       = ovf_r | (enc_upd && !fits);
  end

  always_comb begin
    can_load      = !out_valid_r || out_ch.ready;
    pop           = !q_stat.empty && !busy_r && can_load;
    out_load      = 1'b0;
    res           = '0;
    busy_nxt      = busy_r;
    dec_word_nxt  = dec_word_r;
    remaining_nxt = remaining_r;
    enc_word_nxt  = enc_word_r;
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;

    if (busy_r && can_load) begin
      out_load = 1'b1;
      if (found) begin
        res.kind        = KIND_CHAR;
        res.char_out    = m_ch;
        res.bits_used   = USED_W'(FILL_W'(WORD_BITS) - rem_after);
        res.last_result = (m_ch == CH_PERIOD) || (rem_after == '0);
        dec_word_nxt    = dec_word_r << m_len;
        remaining_nxt   = rem_after;
        busy_nxt        = !res.last_result;
      end else begin
        res.kind        = KIND_NOMATCH;
        res.bits_used   = USED_W'(FILL_W'(WORD_BITS) - remaining_r);
        res.last_result = 1'b1;
        busy_nxt        = 1'b0;
      end
    end else if (pop) begin
      if (head.op == OP_DECODE) begin
        // Load the word; the decoder steps through it while busy is set.
        busy_nxt      = 1'b1;
        dec_word_nxt  = head.word;
        remaining_nxt = FILL_W'(WORD_BITS);
      end else if (head.eot) begin
        out_load        = 1'b1;
        res.packed_out  = OUT_WORD_W'(ew);
        res.kind        = KIND_PACKED;
        res.overflowed  = eo;
        res.bits_used   = USED_W'(FILL_W'(WORD_BITS) - ef);
        res.last_result = 1'b1;
        enc_word_nxt    = '0;
        fill_nxt        = FILL_W'(WORD_BITS);
        ovf_nxt         = 1'b0;
      end else begin
        enc_word_nxt = ew;
        fill_nxt     = ef;
        ovf_nxt      = eo;
      end
    end

    out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
    out_res_nxt   = out_load ? res : out_res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      enc_word_r  <= '0;
      fill_r      <= FILL_W'(WORD_BITS);
      ovf_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      busy_r      <= busy_nxt;
      enc_word_r  <= enc_word_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r   <= out_res_nxt;
    dec_word_r  <= dec_word_nxt;
    remaining_r <= remaining_nxt;
  end

endmodule

@@ rtl/core/fixed_huffman_text_codec_top.sv @@
// Top level of the fixed-table text codec: front end, request queue, back end.
// A packed word passes the request queue, then the result register. A decode
// request passes the queue and loads the decoder, which sends each character to
// the result register and takes no new request until its last result. Encode
// takes 1 character per cycle while no full queue, output stall or decode holds it.
// Reset (rst_n low, synchronous): queue empty, no result pending, encoder word
// cleared with all bits free and overflow flag clear.
module fixed_huffman_text_codec_top (
  input  logic      clk,
  input  logic      rst_n,
  fhc_in_if.sink    in_ch,
  fhc_out_if.source out_ch
);
  import fhc_pkg::*;

  // Front to queue: one classified request per accepted input.
  logic         push;
  fhc_cmd_t     push_cmd;
  // Queue head, seen by the back end, and occupancy, seen by both ends.
  fhc_cmd_t     head;
  fhc_q_stat_t  q_stat;
  // Back end status: busy while a decode walks its word, pop on a queue read.
  fhc_bk_stat_t bk_stat;

  // Classify characters and hold off requests while the queue is full.
  fhc_front u_front (
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Decouple request intake from result delivery.
  fhc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (bk_stat.pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // Advance the encoder, step the decoder and drive the result register.
  fhc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_stat  (q_stat),
    .bk_stat (bk_stat),
    .out_ch  (out_ch)
  );

`ifndef ASSERT_OFF
  // Never read the queue while it is empty.
  a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.pop |-> !q_stat.empty)
    else $error("queue read while empty");

  // A decode in progress blocks the next request.
  a_busy_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.busy |-> !bk_stat.pop)
    else $error("queue read during decode");

  // A request taken with a full queue would be lost.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !q_stat.full)
    else $error("request accepted with queue full");

  // A decode starts only once the pending result can be replaced.
  a_pop_decode_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_stat.pop && head.op == OP_DECODE) |=> bk_stat.busy)
    else $error("decode request did not start the decoder");
`endif

endmodule

@@ tb/sv/fixed_huffman_text_codec_top_tb.sv @@
// Self-checking testbench for the fixed-table text codec: random handshakes, inline predictor.
module fixed_huffman_text_codec_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fhc_pkg::*;

  // Hang guard: worst case is ~250 requests, each up to 22 results, each result
  // stalled by the longest receiver wait, plus sender gaps; take that several times over.
  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_TARGET = 220;
  localparam int PRINT_CAP   = 100;

  // Code table, in decode priority order.
  localparam logic [7:0] TBL_CHAR [29] = '{
    "a", "b", "c", "d", "e", "f", "g", "h", "i", "j", "k", "l", "m", "n", "o",
    "p", "q", "r", "s", "t", "u", "v", "w", "x", "y", "z", ",", ".", " "
  };
  localparam int TBL_LEN [29] = '{
    4, 7, 4, 4, 4, 5, 6, 5, 4, 8, 8, 5, 5, 4, 4,
    5, 8, 5, 4, 4, 5, 8, 7, 8, 6, 8, 7, 6, 3
  };
  localparam logic [7:0] TBL_CODE [29] = '{
    8'h09, 8'h42, 8'h01, 8'h04, 8'h0E, 8'h1B, 8'h00, 8'h1A, 8'h06, 8'h07,
    8'h54, 8'h01, 8'h1E, 8'h07, 8'h0C, 8'h0B, 8'h55, 8'h1F, 8'h03, 8'h02,
    8'h11, 8'h87, 8'h02, 8'h06, 8'h20, 8'h86, 8'h2B, 8'h14, 8'h05
  };
  localparam int IDX_PERIOD = 27;
  localparam int IDX_SPACE  = 28;

  typedef struct {
    fhc_op_t     op;
    logic [7:0]  symbol;
    logic        eot;
    logic [63:0] word;
    bit          drain;  // hold this request until every result is back
  } codec_req_t;

  logic clk;
  logic rst_n;

  fhc_in_if  in_ch ();
  fhc_out_if out_ch ();

  fixed_huffman_text_codec_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Request stream waiting to be driven, and the results the encoder/decoder owe us.
  codec_req_t text_requests [$];
  fhc_res_t   owed_results [$];
  codec_req_t cur_req;

  // Encoder state as the block should hold it.
  logic [63:0] enc_word = '0;
  int          enc_free = WORD_BITS;
  logic        enc_ovf  = 1'b0;

  int  n_queued   = 0;
  int  n_accepted = 0;
  int  n_errors   = 0;
  int  send_wait  = 0;
  int  send_calm  = 0;
  int  recv_wait  = 0;
  int  recv_calm  = 0;
  bit  drain_next = 0;
  int  cycle_count;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Return the table index of a character, or -1 when it has no code.
  function automatic int char_index(input logic [7:0] c);
    int idx;
    idx = -1;
    for (int k = 0; k < NUM_SYMS; k++)
      if (idx < 0 && TBL_CHAR[k] == c) idx = k;
    return idx;
  endfunction

  // Append one character's code; emit and clear the word on end of text.
  task automatic encode_char(input logic [7:0] c, input logic eot);
    int       k;
    fhc_res_t r;
    k = char_index(c);
    // Unknown characters leave the word alone; overflow is sticky until emit.
    if (k >= 0 && !enc_ovf) begin
      if (TBL_LEN[k] > enc_free) begin
        enc_ovf = 1'b1;
      end else begin
        enc_free -= TBL_LEN[k];
        enc_word |= 64'(TBL_CODE[k]) << enc_free;
      end
    end
    if (eot) begin
      r             = '0;
      r.packed_out  = enc_word;
      r.kind        = KIND_PACKED;
      r.overflowed  = enc_ovf;
      r.bits_used   = USED_W'(WORD_BITS - enc_free);
      r.last_result = 1'b1;
      owed_results.push_back(r);
      enc_word = '0;
      enc_free = WORD_BITS;
      enc_ovf  = 1'b0;
    end
  endtask

  // Walk a word from the top bit down, one character per result.
  task automatic decode_word(input logic [63:0] w);
    int       rem;
    int       k_hit;
    bit       done;
    fhc_res_t r;
    rem  = WORD_BITS;
    done = 0;
    while (!done) begin
      k_hit = -1;
      for (int k = 0; k < NUM_SYMS; k++)
        if (k_hit < 0 && TBL_LEN[k] <= rem &&
            ((w >> (rem - TBL_LEN[k])) & ((64'd1 << TBL_LEN[k]) - 64'd1)) == 64'(TBL_CODE[k]))
          k_hit = k;
      r = '0;
      if (k_hit < 0) begin
        // Leftover bits that match no code end the word.
        r.kind = KIND_NOMATCH;
        done   = 1;
      end else begin
        rem       -= TBL_LEN[k_hit];
        r.kind     = KIND_CHAR;
        r.char_out = TBL_CHAR[k_hit];
        // Stop after a period or when the word is used up.
        done       = (k_hit == IDX_PERIOD) || (rem == 0);
      end
      r.bits_used   = USED_W'(WORD_BITS - rem);
      r.last_result = done;
      owed_results.push_back(r);
    end
  endtask

  task automatic predict_request(input codec_req_t q);
    if (q.op == OP_ENCODE) encode_char(q.symbol, q.eot);
    else decode_word(q.word);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_result();
    fhc_res_t want;
    if (owed_results.size() == 0) begin
      report_mismatch($sformatf("result kind %0d with nothing owed", out_ch.kind));
      return;
    end
    want = owed_results.pop_front();
    if (out_ch.packed_out !== want.packed_out)
      report_mismatch($sformatf("packed_out %h, want %h", out_ch.packed_out, want.packed_out));
    if (out_ch.kind !== want.kind)
      report_mismatch($sformatf("kind %0d, want %0d", out_ch.kind, want.kind));
    if (out_ch.char_out !== want.char_out)
      report_mismatch($sformatf("char_out %h, want %h", out_ch.char_out, want.char_out));
    if (out_ch.overflowed !== want.overflowed)
      report_mismatch($sformatf("overflowed %b, want %b", out_ch.overflowed, want.overflowed));
    if (out_ch.bits_used !== want.bits_used)
      report_mismatch($sformatf("bits_used %0d, want %0d", out_ch.bits_used, want.bits_used));
    if (out_ch.last_result !== want.last_result)
      report_mismatch($sformatf("last_result %b, want %b", out_ch.last_result,
                                want.last_result));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Draw a random wait, with occasional stretches of no waiting at all.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  task automatic queue_char(input logic [7:0] c, input logic eot);
    codec_req_t q;
    q.op     = OP_ENCODE;
    q.symbol = c;
    q.eot    = eot;
    q.word   = {$urandom, $urandom};  // ignored on encode
    q.drain  = drain_next;
    drain_next = 0;
    text_requests.push_back(q);
    // Ignored characters do not count toward the target.
    if (eot || char_index(c) >= 0) n_queued++;
  endtask

  task automatic queue_word(input logic [63:0] w);
    codec_req_t q;
    q.op     = OP_DECODE;
    q.symbol = 8'($urandom);  // ignored on decode
    q.eot    = 1'($urandom);
    q.word   = w;
    q.drain  = drain_next;
    drain_next = 0;
    text_requests.push_back(q);
    n_queued++;
  endtask

  // Pack random codes from the top, then pad the unused low bits with noise.
  function automatic logic [63:0] coded_word();
    logic [63:0] w;
    int          free;
    int          k;
    bit          full;
    w    = '0;
    free = WORD_BITS;
    full = 0;
    while (!full) begin
      k = $urandom_range(0, NUM_SYMS - 1);
      // Keep periods rare so most words decode deep.
      if (k == IDX_PERIOD && $urandom_range(0, 3) != 0) k = IDX_SPACE;
      if (TBL_LEN[k] > free) begin
        full = 1;
      end else begin
        free -= TBL_LEN[k];
        w |= 64'(TBL_CODE[k]) << free;
      end
    end
    if (free > 0) w |= {$urandom, $urandom} & ((64'd1 << free) - 64'd1);
    return w;
  endfunction

  // Random text: mostly table characters, some arbitrary bytes, long runs to overflow.
  task automatic queue_sentence();
    int n;
    logic [7:0] c;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 30) : $urandom_range(1, 14);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) c = 8'($urandom);
      else c = TBL_CHAR[$urandom_range(0, NUM_SYMS - 1)];
      queue_char(c, i == n - 1);
      // Now and then slip a decode into the middle of the text.
      if (i != n - 1 && $urandom_range(0, 24) == 0) queue_word(coded_word());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset, initial pin values
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.op          = OP_ENCODE;
    in_ch.symbol      = '0;
    in_ch.end_of_text = 1'b0;
    in_ch.packed_in   = '0;
    out_ch.ready      = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Request driver: present one queued request at a time, hold it until taken
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : request_driver
    logic holding;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      holding = in_ch.valid && !in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        // Request taken: predict its results now, then draw the gap to the next.
        predict_request(cur_req);
        n_accepted++;
        send_wait = draw_wait(send_calm);
      end
      if (!holding) begin
        if (send_wait > 0) begin
          send_wait--;
          in_ch.valid <= 1'b0;
        end else if (text_requests.size() > 0 &&
                     !(text_requests[0].drain && owed_results.size() > 0)) begin
          cur_req = text_requests.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.op          <= cur_req.op;
          in_ch.symbol      <= cur_req.symbol;
          in_ch.end_of_text <= cur_req.eot;
          in_ch.packed_in   <= cur_req.word;
        end else begin
          // Idle, or hold off until the block has drained.
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: check each taken result, then stall ready at random
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : result_monitor
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_result();
        recv_wait = draw_wait(recv_calm);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_ch.ready <= (recv_wait == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Hang guard
  // ---------------------------------------------------------------------------

  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    logic [63:0] spaces;
    rst_n = 1'b0;

    // Directed: single character, empty word, ignored byte before a space.
    queue_char("a", 1'b1);
    queue_char(8'h00, 1'b1);
    queue_char(8'hFF, 1'b0);
    queue_char(" ", 1'b1);
    // Overflow: 7 x 'j' + 'a' fills 60 bits, next 'j' does not fit, and the
    // 's' that would fit is dropped because overflow is sticky.
    for (int i = 0; i < 7; i++) queue_char("j", 1'b0);
    queue_char("a", 1'b0);
    queue_char("j", 1'b0);
    queue_char("s", 1'b1);
    // Decode in the middle of text must not disturb the encoder.
    queue_char("a", 1'b0);
    queue_word(coded_word());
    queue_char("b", 1'b1);
    // Decode corners: all zeros, all ones, lone period, the longest run of
    // short codes ending in a no-match bit, an exactly used-up word.
    queue_word(64'h0);
    queue_word('1);
    queue_word(64'h5000_0000_0000_0000);
    spaces = '0;
    for (int i = 0; i < 21; i++) spaces = (spaces << 3) | 64'b101;
    queue_word(spaces << 1);
    queue_word(64'h9999_9999_9999_9999);

    // Random part: sentences with decodes mixed in; drain fully now and then.
    drain_next = 1;
    while (n_queued < ITEM_TARGET) begin
      if ($urandom_range(0, 19) == 0) drain_next = 1;
      queue_sentence();
      if ($urandom_range(0, 1) == 0) begin
        // Mostly well-formed code words, some raw noise.
        if ($urandom_range(0, 3) == 0) queue_word({$urandom, $urandom});
        else queue_word(coded_word());
      end
    end

    // Hold reset, then release it once.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (text_requests.size() != 0 || in_ch.valid) @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    // Give a stray extra result time to show up.
    repeat (30) @(posedge clk);

    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
